FILE: hdl/erld_pkg.sv
// Package for the escape run-length decoder: types, constants and sizes.
package erld_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 6;

  localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'd48;
  localparam logic [BYTE_W-1:0] MARK_RESET = 8'd42;
  localparam logic [CNT_W-1:0]  MAX_RUN    = 6'd63;

  typedef enum logic [1:0] {
    ST_LIT,
    ST_COUNT,
    ST_VALUE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] diff;
    logic              borrow;
    logic              zero;
    logic              over;
  } sub_res_t;

endpackage

FILE: hdl/escape_rle_decoder_unit.sv
// Top level of the escape run-length decoder: sequencer, run registers, output stage.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+---------------------------------------
//   input     | data_valid_i / data_ready_o  | data_byte_i
//   output    | out_valid_o / out_ready_i    | out_byte_o, run_end_o, count_saturated_o
//   config    | mark_char_we_i (no wait)     | mark_char_i
//
// Literal, mark and count bytes are each taken as soon as the output slot is free.
// After a value byte the block holds input off while it emits the copies of the run;
// the shared subtractor decrements the remaining count. Reset clears the sequencer,
// run count and output valid and sets the mark to '*'. Output back-pressure stalls
// the copy loop and input acceptance; a waiting result holds off the next byte until
// it drains, which may be in the same cycle.
module escape_rle_decoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        mark_char_we_i,
  input  logic [erld_pkg::BYTE_W-1:0] mark_char_i,
  input  logic                        data_valid_i,
  output logic                        data_ready_o,
  input  logic [erld_pkg::BYTE_W-1:0] data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [erld_pkg::BYTE_W-1:0] out_byte_o,
  output logic                        run_end_o,
  output logic                        count_saturated_o
);

  erld_pkg::state_e            st_q, st_d;
  logic [erld_pkg::BYTE_W-1:0] mark_q;
  logic [erld_pkg::CNT_W-1:0]  rem_q, rem_d;
  logic                        sat_q, sat_d;
  logic [erld_pkg::BYTE_W-1:0] val_q, val_d;
  logic                        out_valid_q, out_valid_d;
  logic [erld_pkg::BYTE_W-1:0] out_byte_q, out_byte_d;
  logic                        run_end_q, run_end_d;
  logic                        out_sat_q, out_sat_d;

  logic [erld_pkg::BYTE_W-1:0] sub_a, sub_b;
  erld_pkg::sub_res_t          sub_res;
  logic                        slot_free;
  logic                        in_fire;
  logic                        is_mark;

  // Output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_fire   = data_valid_i && data_ready_o;
  assign is_mark   = (data_byte_i == mark_q);

  // Operand select for the shared unit: copy count while emitting,
  // digit conversion otherwise.
  always_comb begin
    if (st_q == erld_pkg::ST_EMIT) begin
      sub_a = {{(erld_pkg::BYTE_W-erld_pkg::CNT_W){1'b0}}, rem_q};
      sub_b = erld_pkg::BYTE_W'(1);
    end else begin
      sub_a = data_byte_i;
      sub_b = erld_pkg::DIGIT_BASE;
    end
  end

  erld_sub u_sub (
    .a_i  (sub_a),
    .b_i  (sub_b),
    .res_o(sub_res)
  );

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      erld_pkg::ST_LIT: begin
        if (in_fire && is_mark) st_d = erld_pkg::ST_COUNT;
      end
      erld_pkg::ST_COUNT: begin
        if (in_fire) st_d = erld_pkg::ST_VALUE;
      end
      erld_pkg::ST_VALUE: begin
        if (in_fire) st_d = (rem_q == '0) ? erld_pkg::ST_LIT : erld_pkg::ST_EMIT;
      end
      erld_pkg::ST_EMIT: begin
        // last copy leaves the loop
        if (slot_free && sub_res.zero) st_d = erld_pkg::ST_LIT;
      end
      default: st_d = erld_pkg::ST_LIT;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    data_ready_o = 1'b0;
    rem_d        = rem_q;
    sat_d        = sat_q;
    val_d        = val_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    run_end_d    = run_end_q;
    out_sat_d    = out_sat_q;
    case (st_q)
      erld_pkg::ST_LIT: begin
        data_ready_o = slot_free;
        if (in_fire && !is_mark) begin
          // pass the literal straight through
          out_valid_d = 1'b1;
          out_byte_d  = data_byte_i;
          run_end_d   = 1'b1;
          out_sat_d   = 1'b0;
        end
      end
      erld_pkg::ST_COUNT: begin
        data_ready_o = slot_free;
        if (in_fire) begin
          if (sub_res.borrow) begin
            rem_d = '0;
            sat_d = 1'b0;
          end else if (sub_res.over) begin
            rem_d = erld_pkg::MAX_RUN;
            sat_d = 1'b1;
          end else begin
            rem_d = sub_res.diff[erld_pkg::CNT_W-1:0];
            sat_d = 1'b0;
          end
        end
      end
      erld_pkg::ST_VALUE: begin
        data_ready_o = slot_free;
        if (in_fire) begin
          val_d = data_byte_i;
          // empty run: drop the value byte and clear the run state
          if (rem_q == '0) sat_d = 1'b0;
        end
      end
      erld_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = val_q;
          run_end_d   = sub_res.zero;
          out_sat_d   = sat_q;
          rem_d       = sub_res.diff[erld_pkg::CNT_W-1:0];
          if (sub_res.zero) sat_d = 1'b0;
        end
      end
      default: data_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= erld_pkg::ST_LIT;
      mark_q      <= erld_pkg::MARK_RESET;
      rem_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rem_q       <= rem_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
      if (mark_char_we_i) mark_q <= mark_char_i;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    out_byte_q <= out_byte_d;
    run_end_q  <= run_end_d;
    out_sat_q  <= out_sat_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_byte_o        = out_byte_q;
  assign run_end_o         = run_end_q;
  assign count_saturated_o = out_sat_q;

  // A copy loop never runs with nothing left to emit.
  a_emit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == erld_pkg::ST_EMIT) |-> (rem_q != '0))
    else $error("copy loop entered with zero count");

  // The last copy returns the sequencer to literal mode and flags the run end.
  a_last_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == erld_pkg::ST_EMIT && slot_free && rem_q == erld_pkg::CNT_W'(1))
    |=> (st_q == erld_pkg::ST_LIT && out_valid_o && run_end_o))
    else $error("last copy did not end the run");

  // A clamped run carries the limit as its count while it waits for its value byte.
  a_sat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == erld_pkg::ST_VALUE && sat_q) |-> (rem_q == erld_pkg::MAX_RUN))
    else $error("saturated run with wrong count");

  // A literal byte shows up on the output the next cycle, flagged as a run end and not saturated.
  a_literal_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && st_q == erld_pkg::ST_LIT && !is_mark)
    |=> (out_valid_o && out_byte_o == $past(data_byte_i) && run_end_o
         && !count_saturated_o))
    else $error("literal byte not passed through");

endmodule

FILE: hdl/erld_sub.sv
// Shared subtract and compare unit of the escape run-length decoder.
module erld_sub (
  input  logic [erld_pkg::BYTE_W-1:0] a_i,
  input  logic [erld_pkg::BYTE_W-1:0] b_i,
  output erld_pkg::sub_res_t          res_o
);

  logic [erld_pkg::BYTE_W:0] diff_wide;

  assign diff_wide = {1'b0, a_i} - {1'b0, b_i};

  always_comb begin
    res_o.diff   = diff_wide[erld_pkg::BYTE_W-1:0];
    res_o.borrow = diff_wide[erld_pkg::BYTE_W];
    res_o.zero   = (diff_wide == '0);
    // count above the limit, only meaningful without borrow
    res_o.over   = !diff_wide[erld_pkg::BYTE_W] &&
                   (diff_wide[erld_pkg::BYTE_W-1:0] >
                    {{(erld_pkg::BYTE_W-erld_pkg::CNT_W){1'b0}}, erld_pkg::MAX_RUN});
  end

endmodule

FILE: bench/escape_rle_decoder_unit_tb.sv
// Testbench for escape_rle_decoder_unit: random byte streams against a run-decode scoreboard.
`timescale 1ns / 1ps

module escape_rle_decoder_unit_tb;

  localparam int unsigned CLK_PERIOD   = 12;
  // Worst case is ~300 bytes x 63 copies, each behind an output stall; allow several times that.
  localparam int unsigned LIMIT_CYCLES = 600_000;
  // Mark, count and empty-run value bytes leave no trace in the queue; let them retire.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Wait past a full run at the end to catch stray copies.
  localparam int unsigned TAIL_CYCLES  = 80;
  localparam int unsigned PHASE_BYTES  = 64;

  // Tracks the decoder state and holds the copies still due from the block.
  class rle_scoreboard;
    typedef struct packed {
      logic [erld_pkg::BYTE_W-1:0] value;
      logic                        last;
      logic                        sat;
    } copy_t;

    logic [erld_pkg::BYTE_W-1:0] mark;
    erld_pkg::state_e            phase;
    logic [erld_pkg::CNT_W-1:0]  run_len;
    logic                        run_sat;
    copy_t                       copies_due[$];
    int unsigned                 errors;

    function new();
      mark    = erld_pkg::MARK_RESET;
      phase   = erld_pkg::ST_LIT;
      run_len = '0;
      run_sat = 1'b0;
      errors  = 0;
    endfunction

    function void set_mark(logic [erld_pkg::BYTE_W-1:0] m);
      mark = m;
    endfunction

    // Advance the decoder by one accepted byte and queue the copies it yields.
    function void take_byte(logic [erld_pkg::BYTE_W-1:0] b);
      int    digit;
      int    n;
      copy_t c;
      digit = int'(b) - int'(erld_pkg::DIGIT_BASE);
      case (phase)
        erld_pkg::ST_COUNT: begin
          if (digit < 0) begin
            run_len = '0;
            run_sat = 1'b0;
          end else if (digit > int'(erld_pkg::MAX_RUN)) begin
            run_len = erld_pkg::MAX_RUN;
            run_sat = 1'b1;
          end else begin
            run_len = erld_pkg::CNT_W'(digit);
            run_sat = 1'b0;
          end
          phase = erld_pkg::ST_VALUE;
        end
        erld_pkg::ST_VALUE: begin
          n = int'(run_len);
          for (int k = 0; k < n; k++) begin
            c.value = b;
            c.last  = (k == n - 1);
            c.sat   = run_sat;
            copies_due.insert(copies_due.size(), c);
          end
          run_len = '0;
          run_sat = 1'b0;
          phase   = erld_pkg::ST_LIT;
        end
        default: begin
          if (b == mark) begin
            phase = erld_pkg::ST_COUNT;
          end else begin
            c.value = b;
            c.last  = 1'b1;
            c.sat   = 1'b0;
            copies_due.insert(copies_due.size(), c);
            phase = erld_pkg::ST_LIT;
          end
        end
      endcase
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] %s", $time, what);
    endtask

    // Compare one delivered copy with the oldest one due.
    task check_copy(logic [erld_pkg::BYTE_W-1:0] got_byte, logic got_end, logic got_sat);
      copy_t c;
      if (copies_due.size() == 0) begin
        report($sformatf("unexpected result byte %02h end %b sat %b",
                         got_byte, got_end, got_sat));
      end else begin
        c = copies_due.pop_front();
        if (got_byte !== c.value)
          report($sformatf("out_byte %02h, want %02h", got_byte, c.value));
        if (got_end !== c.last)
          report($sformatf("run_end %b, want %b (byte %02h)", got_end, c.last, c.value));
        if (got_sat !== c.sat)
          report($sformatf("count_saturated %b, want %b (byte %02h)",
                           got_sat, c.sat, c.value));
      end
    endtask
  endclass

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        mark_char_we_i = 1'b0;
  logic [erld_pkg::BYTE_W-1:0] mark_char_i    = '0;
  logic                        data_valid_i   = 1'b0;
  logic                        data_ready_o;
  logic [erld_pkg::BYTE_W-1:0] data_byte_i    = '0;
  logic                        out_valid_o;
  logic                        out_ready_i    = 1'b0;
  logic [erld_pkg::BYTE_W-1:0] out_byte_o;
  logic                        run_end_o;
  logic                        count_saturated_o;

  rle_scoreboard sb = new();

  // Set for the closing stretch: no idling on either side.
  bit          calm       = 1'b0;
  int unsigned bytes_sent = 0;
  int          stall_left = 0;

  escape_rle_decoder_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mark_char_we_i    (mark_char_we_i),
    .mark_char_i       (mark_char_i),
    .data_valid_i      (data_valid_i),
    .data_ready_o      (data_ready_o),
    .data_byte_i       (data_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_byte_o        (out_byte_o),
    .run_end_o         (run_end_o),
    .count_saturated_o (count_saturated_o)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // Sample both channels at the rising edge: feed accepted bytes to the
  // scoreboard, then check any delivered copy.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (data_valid_i && data_ready_o) sb.take_byte(data_byte_i);
      if (out_valid_o && out_ready_i)
        sb.check_copy(out_byte_o, run_end_o, count_saturated_o);
    end
  end

  // Drive the result side: stall in random bursts, never while calm.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  = stall_left - 1;
    end else if (!calm && rst_ni && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  = $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Present one byte and hold it until the transaction completes; sometimes
  // drop valid for a short burst first.
  task automatic send_byte(input logic [erld_pkg::BYTE_W-1:0] b);
    int gap;
    @(negedge clk_i);
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      data_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    data_valid_i <= 1'b1;
    data_byte_i  <= b;
    do @(posedge clk_i); while (!data_ready_o);
    bytes_sent++;
  endtask

  // Send a complete escape sequence: mark, count byte, value byte.
  task automatic send_run(input logic [erld_pkg::BYTE_W-1:0] count_b,
                          input logic [erld_pkg::BYTE_W-1:0] value_b);
    send_byte(sb.mark);
    send_byte(count_b);
    send_byte(value_b);
  endtask

  // Drop valid and hold off until every copy due has arrived and the block has settled.
  task automatic wait_drained();
    @(negedge clk_i);
    data_valid_i <= 1'b0;
    while (sb.copies_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write the mark register for one cycle; call only while drained.
  task automatic set_mark(input logic [erld_pkg::BYTE_W-1:0] m);
    @(negedge clk_i);
    mark_char_we_i <= 1'b1;
    mark_char_i    <= m;
    sb.set_mark(m);
    @(negedge clk_i);
    mark_char_we_i <= 1'b0;
  endtask

  // Mostly short digit counts, with empty, long and clamped runs mixed in.
  function automatic logic [erld_pkg::BYTE_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return erld_pkg::BYTE_W'($urandom_range(48, 57));
    if (r < 75) return erld_pkg::BYTE_W'($urandom_range(58, 80));
    if (r < 88) return erld_pkg::BYTE_W'($urandom_range(0, 47));
    if (r < 94) return erld_pkg::BYTE_W'($urandom_range(81, 111));
    return erld_pkg::BYTE_W'($urandom_range(112, 255));
  endfunction

  // Random stream: literals, well-formed runs with random content, and raw noise
  // (which includes bare marks that break a sequence).
  task automatic send_random(input int unsigned n);
    int unsigned                 target;
    int                          r;
    logic [erld_pkg::BYTE_W-1:0] b;
    target = bytes_sent + n;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        b = erld_pkg::BYTE_W'($urandom_range(0, 255));
        if (b == sb.mark) b = ~b;
        send_byte(b);
      end else if (r < 88) begin
        send_run(pick_count(), erld_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        b = ($urandom_range(0, 3) == 0) ? sb.mark
                                        : erld_pkg::BYTE_W'($urandom_range(0, 255));
        send_byte(b);
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset mark '*'.
    send_byte(8'h00);                // literal extremes
    send_byte(8'hFF);
    send_run(8'h33, 8'hA5);          // '3': three copies
    send_run(8'h30, 8'h40);          // '0': empty run
    send_run(8'h00, 8'h11);          // count below zero: empty run
    send_run(8'd111, 8'h5A);         // exactly the longest run, no clamp
    send_run(8'hFF, 8'hFF);          // count far above range: clamped
    send_run(8'h31, 8'h2A);          // value equal to the mark is taken literally

    // Change the mark between mark and count: the open run must finish unchanged.
    send_byte(8'h2A);
    wait_drained();
    set_mark(8'h7E);
    send_byte(8'h32);
    send_byte(8'h2A);
    send_byte(8'h2A);                // old mark now passes through

    // Random phases over several mark settings; each switch waits for a full drain.
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0:       set_mark(8'h00);
        1:       set_mark(8'hFF);
        2:       set_mark(erld_pkg::BYTE_W'($urandom_range(1, 254)));
        default: set_mark(erld_pkg::MARK_RESET);
      endcase
      if (p == 3) calm = 1'b1;
      send_random(PHASE_BYTES);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.copies_due.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.copies_due.size()));

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
